[rtl/core/c_escape_decoder_top_defines.svh]
// Assertion macros shared by the escape decoder RTL.
// Uses the aclk and aresetn ports of the module that expands them.
`ifndef C_ESCAPE_DECODER_TOP_DEFINES_SVH
`define C_ESCAPE_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CESC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CESC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) pre |=> post) else $error(msg);
`else
`define CESC_ASSERT(label, prop, msg)
`define CESC_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

[rtl/core/cesc_pkg.sv]
// Shared types, codes and default settings of the C escape decoder.
// No dependencies; every RTL file of the decoder imports this package.
package cesc_pkg;

    localparam int OCTAL_DIGITS_MAX_DEF = 3;
    localparam int HEX_DIGITS_MAX_DEF   = 63;
    localparam int COUNT_BITS_DEF       = 16;
    localparam int QUEUE_DEPTH_DEF      = 4;

    localparam int BYTE_W      = 8;
    localparam int CAP_W       = 16;
    localparam int OUT_COUNT_W = 16;
    localparam int DIGIT_W     = 6;
    localparam int KIND_W      = 2;
    localparam int CODE_W      = 3;

    // A hex value whose bit length reaches this is at least 2^59.
    localparam logic [DIGIT_W-1:0] HEX_RANGE_BITS = 6'd60;
    localparam logic [CAP_W-1:0]   CAPACITY_RESET = 16'd4096;

    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    localparam logic [CODE_W-1:0] ERR_NONE         = 3'd0;
    localparam logic [CODE_W-1:0] ERR_ILLEGAL      = 3'd1;
    localparam logic [CODE_W-1:0] ERR_UNTERMINATED = 3'd2;
    localparam logic [CODE_W-1:0] ERR_OVERFLOW     = 3'd3;
    localparam logic [CODE_W-1:0] ERR_HEX_RANGE    = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              is_zero;
        logic              is_bslash;
        logic              is_oct;
        logic              is_x;
        logic              is_hex;
        logic [3:0]        hex_val;
        logic              is_simple;
        logic [BYTE_W-1:0] simple_val;
    } cesc_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]      out_byte;
        logic [KIND_W-1:0]      kind;
        logic [CODE_W-1:0]      error_code;
        logic [OUT_COUNT_W-1:0] out_count;
        logic                   end_mark;
    } cesc_result_t;

endpackage

[rtl/core/c_escape_decoder_top.sv]
// Top level of the streaming C escape decoder with its capacity register.
// Depends on cesc_pkg, cesc_front, cesc_queue and cesc_back.
//
// The block takes one source byte per request and returns decoded bytes, an end result or an
// error result on the output stream. Each result takes its own step of the back-end decoder,
// and a byte that closes an octal or hex run can yield up to three results (the flushed escape
// byte, its own byte and the end result). A queue of QUEUE_DEPTH classified bytes lies
// between the front end and the decoder; a registered result stage holds a result until it is
// taken, while the queue keeps the input flowing until it is full. The user must write the
// capacity register on its own channel only while the block is idle; it is not enforced.
module c_escape_decoder_top import cesc_pkg::*; #(
    parameter int OCTAL_DIGITS_MAX = OCTAL_DIGITS_MAX_DEF,
    parameter int HEX_DIGITS_MAX   = HEX_DIGITS_MAX_DEF,
    parameter int COUNT_BITS       = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // in_byte[7:0]
    input  logic             s_tlast,   // in_last
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // out_byte[7:0], out_count[23:8]
    output logic [7:0]       m_tuser,   // kind[1:0], error_code[4:2], zero[7:5]
    output logic             m_tlast,   // end_mark
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data   // capacity
);

    logic [CAP_W-1:0] capacity_reg;
    logic             q_push;
    logic             q_ready;
    cesc_item_t       push_item;
    logic             q_valid;
    logic             q_pop;
    cesc_item_t       head_item;
    cesc_result_t     result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            capacity_reg <= cfg_data;
        end
    end

    cesc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    cesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_push  (q_push),
        .wr_ready (q_ready),
        .wr_item  (push_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (head_item)
    );

    cesc_back #(
        .OCTAL_DIGITS_MAX (OCTAL_DIGITS_MAX),
        .HEX_DIGITS_MAX   (HEX_DIGITS_MAX),
        .COUNT_BITS       (COUNT_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capacity (capacity_reg),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = {result.out_count, result.out_byte};
    assign m_tuser = {3'b000, result.error_code, result.kind};
    assign m_tlast = result.end_mark;

endmodule

[rtl/core/cesc_front.sv]
// Front end of the escape decoder: takes source bytes and classifies them.
// Depends on cesc_pkg; feeds cesc_queue.
module cesc_front import cesc_pkg::*; (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // in_byte[7:0]
    input  logic              s_tlast,
    input  logic              q_ready,
    output logic              q_push,
    output cesc_item_t        q_item
);

    logic [BYTE_W-1:0] c;

    assign c        = s_tdata;
    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        q_item           = '0;
        q_item.data      = c;
        q_item.last      = s_tlast;
        q_item.is_zero   = (c == 8'h00);
        q_item.is_bslash = (c == 8'h5C);
        q_item.is_oct    = (c >= 8'h30) && (c <= 8'h37);
        q_item.is_x      = (c == 8'h78);
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            q_item.is_hex  = 1'b1;
            q_item.hex_val = 4'(c - 8'h30);
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            q_item.is_hex  = 1'b1;
            q_item.hex_val = 4'(c - 8'h57);
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            q_item.is_hex  = 1'b1;
            q_item.hex_val = 4'(c - 8'h37);
        end
        q_item.is_simple = 1'b1;
        unique case (c)
            8'h5C: q_item.simple_val = 8'h5C;
            8'h61: q_item.simple_val = 8'h07;
            8'h62: q_item.simple_val = 8'h08;
            8'h66: q_item.simple_val = 8'h0C;
            8'h6E: q_item.simple_val = 8'h0A;
            8'h72: q_item.simple_val = 8'h0D;
            8'h74: q_item.simple_val = 8'h09;
            8'h76: q_item.simple_val = 8'h0B;
            default: begin
                q_item.is_simple  = 1'b0;
                q_item.simple_val = 8'h00;
            end
        endcase
    end

endmodule

[rtl/core/cesc_queue.sv]
// Short queue of classified source bytes between front and back end.
// Depends on cesc_pkg and the assertion macros header.
`include "c_escape_decoder_top_defines.svh"
module cesc_queue import cesc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_push,
    output logic       wr_ready,
    input  cesc_item_t wr_item,
    output logic       rd_valid,
    input  logic       rd_pop,
    output cesc_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cesc_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_pop   = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!wr_push && do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `CESC_ASSERT(a_queue_bound, (count_reg <= CNT_W'(DEPTH)), "queue holds more than its depth")

endmodule

[rtl/core/cesc_back.sv]
// Back end of the escape decoder: escape state machine and result register.
// Depends on cesc_pkg and the assertion macros header; reads cesc_queue.
`include "c_escape_decoder_top_defines.svh"
module cesc_back import cesc_pkg::*; #(
    parameter int OCTAL_DIGITS_MAX = OCTAL_DIGITS_MAX_DEF,
    parameter int HEX_DIGITS_MAX   = HEX_DIGITS_MAX_DEF,
    parameter int COUNT_BITS       = COUNT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CAP_W-1:0] capacity,
    input  logic             q_valid,
    input  cesc_item_t       q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output cesc_result_t     m_result
);

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_OCT,
        MODE_HEX,
        MODE_DONE
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [BYTE_W-1:0]      value_reg, value_next;
    logic [DIGIT_W-1:0]     digits_reg, digits_next;
    logic [DIGIT_W-1:0]     bits_reg, bits_next;
    logic                   herr_reg, herr_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg;
    cesc_result_t           out_res_reg;

    logic                   out_free;
    logic                   step;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [31:0]            cnt_wide;
    logic [31:0]            inc_wide;
    logic                   over;
    logic [DIGIT_W-1:0]     dig_inc;
    logic                   herr_new;
    logic [BYTE_W-1:0]      oct_val;
    logic [BYTE_W-1:0]      hex_val;
    logic                   do_put;
    logic [BYTE_W-1:0]      put_val;
    logic                   set_pend;
    logic                   do_close;
    logic [KIND_W-1:0]      close_kind;
    logic [CODE_W-1:0]      close_code;
    logic                   res_valid;
    cesc_result_t           res;

    function automatic logic [2:0] bit_len(input logic [3:0] d);
        logic [2:0] n;
        if (d[3]) begin
            n = 3'd4;
        end else if (d[2]) begin
            n = 3'd3;
        end else if (d[1]) begin
            n = 3'd2;
        end else begin
            n = {2'b00, d[0]};
        end
        return n;
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign step     = q_valid && out_free;
    assign cnt_inc  = count_reg + COUNT_BITS'(1);
    assign cnt_wide = 32'(count_reg);
    assign inc_wide = 32'(cnt_inc);
    assign over     = (33'(count_reg) + 33'd1) >= 33'(capacity);
    assign dig_inc  = digits_reg + 6'd1;
    assign herr_new = herr_reg || (bits_reg >= HEX_RANGE_BITS);
    assign oct_val  = {value_reg[4:0], q_item.data[2:0]};
    assign hex_val  = {value_reg[3:0], q_item.hex_val};
    assign m_tvalid = out_valid_reg;
    assign m_result = out_res_reg;

    always_comb begin
        mode_next   = mode_reg;
        value_next  = value_reg;
        digits_next = digits_reg;
        bits_next   = bits_reg;
        herr_next   = herr_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        q_pop       = 1'b0;
        do_put      = 1'b0;
        put_val     = '0;
        set_pend    = 1'b0;
        do_close    = 1'b0;
        close_kind  = KIND_END;
        close_code  = ERR_NONE;
        res_valid   = 1'b0;
        res         = '0;

        if (step) begin
            if (pend_reg) begin
                do_close = 1'b1;
            end else begin
                unique case (mode_reg)
                    MODE_PLAIN: begin
                        if (q_item.is_zero) begin
                            do_close = 1'b1;
                        end else if (over) begin
                            do_close   = 1'b1;
                            close_kind = KIND_ERROR;
                            close_code = ERR_OVERFLOW;
                        end else if (q_item.is_bslash) begin
                            if (q_item.last) begin
                                do_close   = 1'b1;
                                close_kind = KIND_ERROR;
                                close_code = ERR_UNTERMINATED;
                            end else begin
                                mode_next = MODE_ESC;
                                q_pop     = 1'b1;
                            end
                        end else begin
                            do_put  = 1'b1;
                            put_val = q_item.data;
                            if (q_item.last) begin
                                set_pend = 1'b1;
                            end else begin
                                q_pop = 1'b1;
                            end
                        end
                    end
                    MODE_ESC: begin
                        if (q_item.is_zero) begin
                            do_close   = 1'b1;
                            close_kind = KIND_ERROR;
                            close_code = ERR_UNTERMINATED;
                        end else if (q_item.is_oct) begin
                            value_next  = {5'b00000, q_item.data[2:0]};
                            digits_next = 6'd1;
                            mode_next   = MODE_OCT;
                            if ((6'd1 >= 6'(OCTAL_DIGITS_MAX)) || q_item.last) begin
                                mode_next = MODE_PLAIN;
                                do_put    = 1'b1;
                                put_val   = {5'b00000, q_item.data[2:0]};
                                set_pend  = q_item.last;
                            end
                            q_pop = !q_item.last;
                        end else if (q_item.is_x) begin
                            value_next  = '0;
                            digits_next = '0;
                            bits_next   = '0;
                            herr_next   = 1'b0;
                            mode_next   = MODE_HEX;
                            if (q_item.last) begin
                                mode_next = MODE_PLAIN;
                                do_put    = 1'b1;
                                set_pend  = 1'b1;
                            end else begin
                                q_pop = 1'b1;
                            end
                        end else if (q_item.is_simple) begin
                            mode_next = MODE_PLAIN;
                            do_put    = 1'b1;
                            put_val   = q_item.simple_val;
                            set_pend  = q_item.last;
                            q_pop     = !q_item.last;
                        end else begin
                            do_close   = 1'b1;
                            close_kind = KIND_ERROR;
                            close_code = ERR_ILLEGAL;
                        end
                    end
                    MODE_OCT: begin
                        if (q_item.is_oct) begin
                            value_next  = oct_val;
                            digits_next = dig_inc;
                            if ((dig_inc >= 6'(OCTAL_DIGITS_MAX)) || q_item.last) begin
                                mode_next = MODE_PLAIN;
                                do_put    = 1'b1;
                                put_val   = oct_val;
                                set_pend  = q_item.last;
                            end
                            q_pop = !q_item.last;
                        end else begin
                            mode_next = MODE_PLAIN;
                            do_put    = 1'b1;
                            put_val   = value_reg;
                        end
                    end
                    MODE_HEX: begin
                        if (q_item.is_hex) begin
                            herr_next   = herr_new;
                            value_next  = hex_val;
                            digits_next = dig_inc;
                            if (bits_reg == '0) begin
                                bits_next = 6'(bit_len(q_item.hex_val));
                            end else if (bits_reg < HEX_RANGE_BITS) begin
                                bits_next = bits_reg + 6'd4;
                            end
                            if ((dig_inc >= 6'(HEX_DIGITS_MAX)) || q_item.last) begin
                                mode_next = MODE_PLAIN;
                                if (herr_new) begin
                                    do_close   = 1'b1;
                                    close_kind = KIND_ERROR;
                                    close_code = ERR_HEX_RANGE;
                                end else begin
                                    do_put   = 1'b1;
                                    put_val  = hex_val;
                                    set_pend = q_item.last;
                                    q_pop    = !q_item.last;
                                end
                            end else begin
                                q_pop = 1'b1;
                            end
                        end else begin
                            mode_next = MODE_PLAIN;
                            if (herr_reg) begin
                                do_close   = 1'b1;
                                close_kind = KIND_ERROR;
                                close_code = ERR_HEX_RANGE;
                            end else begin
                                do_put  = 1'b1;
                                put_val = value_reg;
                            end
                        end
                    end
                    MODE_DONE: begin
                        if (q_item.last) begin
                            mode_next = MODE_PLAIN;
                        end
                        q_pop = 1'b1;
                    end
                    default: begin
                        mode_next = MODE_PLAIN;
                    end
                endcase
            end

            if (do_put) begin
                res_valid      = 1'b1;
                res.out_byte   = put_val;
                res.kind       = KIND_BYTE;
                res.error_code = ERR_NONE;
                res.out_count  = inc_wide[OUT_COUNT_W-1:0];
                res.end_mark   = 1'b0;
                count_next     = cnt_inc;
                if (set_pend) begin
                    pend_next = 1'b1;
                end
            end

            if (do_close) begin
                res_valid      = 1'b1;
                res.out_byte   = '0;
                res.kind       = close_kind;
                res.error_code = close_code;
                res.out_count  = cnt_wide[OUT_COUNT_W-1:0];
                res.end_mark   = 1'b1;
                mode_next      = q_item.last ? MODE_PLAIN : MODE_DONE;
                count_next     = '0;
                value_next     = '0;
                digits_next    = '0;
                bits_next      = '0;
                herr_next      = 1'b0;
                pend_next      = 1'b0;
                q_pop          = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_PLAIN;
            value_reg     <= '0;
            digits_reg    <= '0;
            bits_reg      <= '0;
            herr_reg      <= 1'b0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            value_reg  <= value_next;
            digits_reg <= digits_next;
            bits_reg   <= bits_next;
            herr_reg   <= herr_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            if (out_free) begin
                out_valid_reg <= res_valid;
                if (res_valid) begin
                    out_res_reg <= res;
                end
            end
        end
    end

    `CESC_ASSERT(a_pend_plain, (pend_reg |-> (mode_reg == MODE_PLAIN)), "pending end outside plain text")
    `CESC_ASSERT(a_hex_digits, ((mode_reg == MODE_HEX) |-> (digits_reg < 6'(HEX_DIGITS_MAX))), "hex run too long")
    `CESC_ASSERT_NEXT(a_pend_close, (step && pend_reg), (!pend_reg && out_valid_reg && out_res_reg.end_mark), "pending end not issued")

endmodule
